@@ design/text_console_writer_core_macros.svh @@
// Assertion macros shared by the console writer modules.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcw: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcw: next-cycle check failed");

`endif

@@ design/tcw_pkg.sv @@
// Shared types and constants of the text console writer.
package tcw_pkg;

	// Field widths of the request and response items
	localparam int unsigned CMD_W      = 1;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned CELL_ADR_W = 11;
	localparam int unsigned COL_OUT_W  = 7;
	localparam int unsigned ROW_OUT_W  = 5;
	localparam int unsigned WORD_W     = 16;
	localparam int unsigned ADR_CMP_W  = 16;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

	// Character codes and the fixed attribute byte
	localparam logic [CHAR_W-1:0] NUL_CHAR     = 8'h00;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] ATTR_BYTE    = 8'h07;

	// Controller to datapath commands
	typedef struct packed {
		logic in_ready;
		logic sweep;
		logic load_read;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic take_read;
		logic put_clears;
		logic sweep_last;
		logic out_free;
	} dp_status_t;

endpackage

@@ design/tcw_if.sv @@
// Request and response channel interfaces of the text console writer.
interface tcw_req_if;
	logic                            valid;
	logic                            ready;
	logic [tcw_pkg::CMD_W-1:0]       command;
	logic [tcw_pkg::CHAR_W-1:0]      char_code;
	logic [tcw_pkg::CELL_ADR_W-1:0]  cell_address;

	modport source (output valid, command, char_code, cell_address, input ready);
	modport sink (input valid, command, char_code, cell_address, output ready);
endinterface

interface tcw_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [tcw_pkg::COL_OUT_W-1:0]  cursor_column;
	logic [tcw_pkg::ROW_OUT_W-1:0]  cursor_row;
	logic [tcw_pkg::WORD_W-1:0]     cell_word;
	logic                           screen_cleared;

	modport source (output valid, cursor_column, cursor_row, cell_word, screen_cleared,
		input ready);
	modport sink (input valid, cursor_column, cursor_row, cell_word, screen_cleared,
		output ready);
endinterface

@@ design/tcw_ctrl.sv @@
// Controller state machine: clearing sweep, request intake and cell read.
`include "text_console_writer_core_macros.svh"

module tcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  tcw_pkg::dp_status_t sts,
	output tcw_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ
	} state_t;

	state_t state_q;

	// Drive commands from the current state
	always_comb begin
		cmd           = '0;
		cmd.in_ready  = (state_q == ST_IDLE) && sts.out_free;
		cmd.sweep     = (state_q == ST_CLEAR);
		cmd.load_read = (state_q == ST_READ);
	end

	// Advance state; reset starts with a full clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.sweep_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (sts.take_read) state_q <= ST_READ;
					else if (sts.put_clears) state_q <= ST_CLEAR;
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	`TCW_ASSERT_NEXT(a_read_loads, clk, arst_n, sts.take_read, cmd.load_read)
	`TCW_ASSERT_NEXT(a_clear_sweeps, clk, arst_n, sts.put_clears, cmd.sweep && !cmd.in_ready)
	`TCW_ASSERT_NEXT(a_sweep_ends, clk, arst_n, cmd.sweep && sts.sweep_last,
		state_q == ST_IDLE)

endmodule

@@ design/tcw_dp.sv @@
// Datapath: cursor, character store, clearing counter and response register.
`include "text_console_writer_core_macros.svh"

module tcw_dp #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcw_pkg::ctrl_cmd_t   cmd,
	output tcw_pkg::dp_status_t  sts,
	tcw_req_if.sink              req,
	tcw_rsp_if.source            rsp
);

	localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
	localparam int unsigned COL_W      = $clog2(COLUMNS);
	localparam int unsigned ROW_W      = $clog2(ROWS);
	localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);

	// Cursor and sweep state
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] sweep_q;

	// Character store; attribute bytes never change and are not kept
	logic [tcw_pkg::CHAR_W-1:0] mem_q [CELL_COUNT];
	logic [tcw_pkg::CHAR_W-1:0] rd_char_q;
	logic                       rd_oor_q;

	// Response register
	logic                            out_valid_q;
	logic [tcw_pkg::COL_OUT_W-1:0]   out_col_q;
	logic [tcw_pkg::ROW_OUT_W-1:0]   out_row_q;
	logic [tcw_pkg::WORD_W-1:0]      out_word_q;
	logic                            out_clr_q;

	logic                            accept;
	logic                            take_put;
	logic                            take_read;
	logic                            is_nul;
	logic                            is_nl;
	logic                            do_put;
	logic [COL_W:0]                  col_inc;
	logic [ROW_W:0]                  row_inc;
	logic                            col_wrap;
	logic                            row_adv;
	logic                            row_over;
	logic                            put_clears;
	logic [COL_W-1:0]                col_nxt;
	logic [ROW_W-1:0]                row_nxt;
	logic [ADDR_W-1:0]               wr_idx;
	logic [ADDR_W-1:0]               rd_idx;
	logic [tcw_pkg::ADR_CMP_W-1:0]   addr_ext;
	logic                            rd_oor;
	logic                            sweep_last;
	logic                            mem_we;
	logic [ADDR_W-1:0]               mem_wa;
	logic [tcw_pkg::CHAR_W-1:0]      mem_wd;
	logic                            out_free;

	// Decode the accepted request
	assign accept    = req.valid && cmd.in_ready;
	assign take_put  = accept && (req.command == tcw_pkg::CMD_PUT);
	assign take_read = accept && (req.command == tcw_pkg::CMD_READ);
	assign is_nul    = (req.char_code == tcw_pkg::NUL_CHAR);
	assign is_nl     = (req.char_code == tcw_pkg::NEWLINE_CHAR);
	assign do_put    = take_put && !is_nul;

	// Work out the cursor after a put
	assign col_inc    = {1'b0, col_q} + (COL_W+1)'(1);
	assign row_inc    = {1'b0, row_q} + (ROW_W+1)'(1);
	assign col_wrap   = (col_inc == (COL_W+1)'(COLUMNS));
	assign row_adv    = is_nl || col_wrap;
	assign row_over   = row_adv && (row_inc == (ROW_W+1)'(ROWS));
	assign put_clears = do_put && row_over;

	always_comb begin
		col_nxt = col_q;
		row_nxt = row_q;
		if (do_put) begin
			if (row_over) begin
				col_nxt = '0;
				row_nxt = '0;
			end else if (row_adv) begin
				col_nxt = '0;
				row_nxt = row_inc[ROW_W-1:0];
			end else begin
				col_nxt = col_inc[COL_W-1:0];
			end
		end
	end

	// Cell addresses for the put and the read
	assign wr_idx   = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign addr_ext = tcw_pkg::ADR_CMP_W'(req.cell_address);
	assign rd_oor   = (addr_ext >= tcw_pkg::ADR_CMP_W'(CELL_COUNT));
	assign rd_idx   = addr_ext[ADDR_W-1:0];

	// Select the single store write: sweep blanks, a put writes its character (not NUL or newline)
	assign sweep_last = (sweep_q == ADDR_W'(CELL_COUNT - 1));
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wr_idx;
		mem_wd = req.char_code;
		if (cmd.sweep) begin
			mem_we = 1'b1;
			mem_wa = sweep_q;
			mem_wd = tcw_pkg::SPACE_CHAR;
		end else if (do_put && !is_nl) begin
			mem_we = 1'b1;
		end
	end

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		if (take_read) begin
			rd_char_q <= mem_q[rd_idx];
			rd_oor_q  <= rd_oor;
		end
	end

	// Hold the cursor and the sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			sweep_q <= '0;
		end else begin
			col_q <= col_nxt;
			row_q <= row_nxt;
			if (cmd.sweep) sweep_q <= sweep_last ? '0 : sweep_q + ADDR_W'(1);
		end
	end

	// Load the response register on a put or when read data arrives; drop it when taken
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_put || cmd.load_read) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_put) begin
			out_col_q  <= tcw_pkg::COL_OUT_W'(col_nxt);
			out_row_q  <= tcw_pkg::ROW_OUT_W'(row_nxt);
			out_word_q <= '0;
			out_clr_q  <= put_clears;
		end else if (cmd.load_read) begin
			out_col_q  <= tcw_pkg::COL_OUT_W'(col_q);
			out_row_q  <= tcw_pkg::ROW_OUT_W'(row_q);
			out_word_q <= rd_oor_q ? '0 : {tcw_pkg::ATTR_BYTE, rd_char_q};
			out_clr_q  <= 1'b0;
		end
	end

	assign req.ready          = cmd.in_ready;
	assign rsp.valid          = out_valid_q;
	assign rsp.cursor_column  = out_col_q;
	assign rsp.cursor_row     = out_row_q;
	assign rsp.cell_word      = out_word_q;
	assign rsp.screen_cleared = out_clr_q;

	always_comb begin
		sts            = '0;
		sts.take_read  = take_read;
		sts.put_clears = put_clears;
		sts.sweep_last = sweep_last;
		sts.out_free   = out_free;
	end

	`TCW_ASSERT_NOW(a_read_slot_free, clk, arst_n, cmd.load_read, !out_valid_q)
	`TCW_ASSERT_NEXT(a_clear_homes, clk, arst_n, put_clears,
		col_q == '0 && row_q == '0 && sweep_q == '0)
	`TCW_ASSERT_NOW(a_sweep_no_intake, clk, arst_n, cmd.sweep, !accept)

endmodule

@@ design/text_console_writer_core.sv @@
// Put: response registered in the cycle after the request; puts go one per cycle while rsp is ready.
// Read: the store read port output is registered first, then loaded into the response register.
// A put that runs past the last row blanks all COLUMNS*ROWS cells, one per cycle (2000 default).
// During that sweep no request is taken; the response of the clearing put is already out.
// Reset: cursor home, response empty, and the same sweep fills the store with spaces.
module text_console_writer_core #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic         clk,
	input  logic         arst_n,
	tcw_req_if.sink      req_ch,
	tcw_rsp_if.source    rsp_ch
);

	tcw_pkg::ctrl_cmd_t  cmd;
	tcw_pkg::dp_status_t sts;

	// Sequence the sweep, intake and read
	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Hold the cursor, store and response
	tcw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

endmodule
